// ===== rtl/core/slc_pkg.sv =====
// ----------------------------------------------------------------------------
// slc_pkg: shared types and constants of the set-associative cache model
// Request and config codes, sequencer states and the lookup result record.
// ----------------------------------------------------------------------------
package slc_pkg;

  localparam int unsigned MAX_SETS_DEF   = 1024;
  localparam int unsigned MAX_WAYS_DEF   = 8;
  localparam int unsigned ADDR_BITS_DEF  = 32;
  localparam int unsigned WORD_BYTES_DEF = 4;

  localparam int unsigned REQ_W     = 2;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned FETCH_W   = 11;
  localparam int unsigned CB_W      = 25;
  localparam int unsigned WORDS_W   = 13;
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD  = 2'd0,
    REQ_STORE = 2'd1,
    REQ_FETCH = 2'd2,
    REQ_FLUSH = 2'd3
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPLIT      = 3'd0,
    CFG_BLOCK_LOG2 = 3'd1,
    CFG_FIRST_SETS = 3'd2,
    CFG_DATA_SETS  = 3'd3,
    CFG_WAYS       = 3'd4,
    CFG_WRITE_BACK = 3'd5,
    CFG_WRITE_ALLOC = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_FLUSH,
    ST_FLUSH_TAIL,
    ST_FLUSH_MUL,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic               hit;
    logic               row_we;
    logic [FETCH_W-1:0] fetch_words;
    logic [CB_W-1:0]    copyback_words;
  } lk_res_t;

endpackage

// ===== rtl/core/slc_if.sv =====
// ----------------------------------------------------------------------------
// slc_if: request and response channels
// Valid/ready channels carrying one access and one access result.
// ----------------------------------------------------------------------------
interface slc_req_if;
  logic                        valid;
  logic                        ready;
  logic [slc_pkg::REQ_W-1:0]   req_type;
  logic [slc_pkg::ADDR_W-1:0]  address;

  modport source (output valid, output req_type, output address, input ready);
  modport sink   (input valid, input req_type, input address, output ready);
endinterface

interface slc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic                          data_side;
  logic [slc_pkg::FETCH_W-1:0]   fetch_words;
  logic [slc_pkg::CB_W-1:0]      copyback_words;

  modport source (output valid, output hit, output data_side, output fetch_words,
                  output copyback_words, input ready);
  modport sink   (input valid, input hit, input data_side, input fetch_words,
                  input copyback_words, output ready);
endinterface

// ===== rtl/core/set_assoc_lru_cache_model.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model: set-associative lru cache model
// Unified or split cache bookkeeping with write-back and allocate policies.
// ----------------------------------------------------------------------------
// After reset the block sweeps its row memory, one set row per cycle, over all
// 2*MAX_SETS rows (2048 by default) and accepts no request meanwhile;
// configuration writes are taken at any time. A load, store or fetch is
// accepted in the idle cycle and then passes through the set row read, the
// lookup and row write-back and the result step, which waits while the
// previous result is not taken. A flush reads every row of both cache halves
// through the same read port and then passes its result on in the same way.
// Results sit in an output register, and the next request is taken while the
// previous result still waits; one result comes out for every request.
module set_assoc_lru_cache_model #(
  parameter int unsigned MAX_SETS   = slc_pkg::MAX_SETS_DEF,
  parameter int unsigned MAX_WAYS   = slc_pkg::MAX_WAYS_DEF,
  parameter int unsigned ADDR_BITS  = slc_pkg::ADDR_BITS_DEF,
  parameter int unsigned WORD_BYTES = slc_pkg::WORD_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [slc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [slc_pkg::CFG_W-1:0]       cfg_data_i,
  slc_req_if.sink                         req_i,
  slc_rsp_if.source                       rsp_o
);

  localparam int unsigned AW      = (ADDR_BITS < slc_pkg::ADDR_W) ? ADDR_BITS
                                                                   : slc_pkg::ADDR_W;
  localparam int unsigned TAG_W   = AW - 2;
  localparam int unsigned AGE_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned NW_W    = $clog2(MAX_WAYS + 1);
  localparam int unsigned ROWS    = 2 * MAX_SETS;
  localparam int unsigned RW      = $clog2(ROWS);
  localparam int unsigned SW      = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned SMAX_F  = $clog2(MAX_SETS + 1) - 1;
  localparam int unsigned SMAX    = (SMAX_F > 10) ? 10 : SMAX_F;
  localparam int unsigned ENTRY_W = TAG_W + 2 + AGE_W;
  localparam int unsigned ROW_W   = MAX_WAYS * ENTRY_W;
  localparam int unsigned CNT_W   = $clog2(ROWS * MAX_WAYS + 1);
  localparam int unsigned WORDS_W = slc_pkg::WORDS_W;

  // configuration registers
  logic                       split_q, write_back_q, write_alloc_q;
  logic [slc_pkg::CFG_W-1:0]  block_log2_q, first_sets_q, data_sets_q, ways_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_q       <= 1'b0;
      block_log2_q  <= 4'd4;
      first_sets_q  <= 4'd6;
      data_sets_q   <= 4'd6;
      ways_q        <= 4'd1;
      write_back_q  <= 1'b1;
      write_alloc_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (slc_pkg::cfg_idx_e'(cfg_idx_i))
        slc_pkg::CFG_SPLIT:       split_q       <= cfg_data_i[0];
        slc_pkg::CFG_BLOCK_LOG2:  block_log2_q  <= cfg_data_i;
        slc_pkg::CFG_FIRST_SETS:  first_sets_q  <= cfg_data_i;
        slc_pkg::CFG_DATA_SETS:   data_sets_q   <= cfg_data_i;
        slc_pkg::CFG_WAYS:        ways_q        <= cfg_data_i;
        slc_pkg::CFG_WRITE_BACK:  write_back_q  <= cfg_data_i[0];
        slc_pkg::CFG_WRITE_ALLOC: write_alloc_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // words per block for every block size code
  logic [WORDS_W-1:0] words_tab [16];
  for (genvar g = 0; g < 16; g++) begin : g_words
    localparam int unsigned WQ = (1 << g) / WORD_BYTES;
    assign words_tab[g] = (WQ == 0) ? WORDS_W'(1) : WORDS_W'(WQ);
  end

  // sequencer registers
  slc_pkg::state_e            state_q, state_d;
  slc_pkg::req_type_e         type_q, type_d;
  logic [AW-1:0]              addr_q, addr_d;
  logic [RW-1:0]              sweep_q, sweep_d;
  logic                       pend_q, pend_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  slc_pkg::lk_res_t           res_q, res_d;
  logic                       rsp_valid_q, rsp_valid_d;
  slc_pkg::lk_res_t           rsp_q, rsp_d;
  logic                       rsp_data_q, rsp_data_d;

  // effective geometry
  logic [3:0]                 blk, sreg, sclamp, seff;
  logic [4:0]                 tag_sh;
  logic [NW_W-1:0]            nw;
  logic                       data_req, region;
  logic [SW-1:0]              set_idx;
  logic [RW-1:0]              row;
  logic [TAG_W-1:0]           req_tag;
  logic [WORDS_W-1:0]         words;
  logic [AW-1:0]              set_mask;

  always_comb begin
    blk      = (block_log2_q < 4'd2) ? 4'd2 : ((block_log2_q > 4'd12) ? 4'd12 : block_log2_q);
    data_req = (type_q == slc_pkg::REQ_LOAD) || (type_q == slc_pkg::REQ_STORE);
    region   = split_q && data_req;
    sreg     = region ? data_sets_q : first_sets_q;
    sclamp   = (sreg > 4'd10) ? 4'd10 : sreg;
    seff     = (sclamp > 4'(SMAX)) ? 4'(SMAX) : sclamp;
    set_mask = (AW'(1) << seff) - 1'b1;
    set_idx  = SW'((addr_q >> blk) & set_mask);
    row      = region ? RW'(MAX_SETS) + RW'(set_idx) : RW'(set_idx);
    tag_sh   = 5'(blk) + 5'(seff);
    req_tag  = TAG_W'(addr_q >> tag_sh);
    nw       = (ways_q == '0) ? NW_W'(1)
             : ((5'(ways_q) > 5'(MAX_WAYS)) ? NW_W'(MAX_WAYS) : NW_W'(ways_q));
    words    = words_tab[blk];
  end

  // row memory
  logic               mem_we, mem_re;
  logic [RW-1:0]      mem_waddr, mem_raddr;
  logic [ROW_W-1:0]   mem_wdata, mem_rdata;

  slc_row_mem #(.DEPTH(ROWS), .WIDTH(ROW_W)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // row unpack and pack
  logic [TAG_W-1:0]    rd_tag [MAX_WAYS];
  logic [AGE_W-1:0]    rd_age [MAX_WAYS];
  logic [MAX_WAYS-1:0] rd_valid, rd_dirty;
  logic [TAG_W-1:0]    wr_tag [MAX_WAYS];
  logic [AGE_W-1:0]    wr_age [MAX_WAYS];
  logic [MAX_WAYS-1:0] wr_valid, wr_dirty;
  logic [ROW_W-1:0]    upd_row;
  logic [CNT_W-1:0]    row_pop;

  always_comb begin
    row_pop = '0;
    for (int k = 0; k < MAX_WAYS; k++) begin
      {rd_tag[k], rd_valid[k], rd_dirty[k], rd_age[k]} = mem_rdata[k*ENTRY_W +: ENTRY_W];
      upd_row[k*ENTRY_W +: ENTRY_W] = {wr_tag[k], wr_valid[k], wr_dirty[k], wr_age[k]};
      row_pop = row_pop + CNT_W'(rd_valid[k] && rd_dirty[k]);
    end
  end

  slc_pkg::lk_res_t lk;

  slc_way_logic #(
    .MAX_WAYS (MAX_WAYS),
    .TAG_W    (TAG_W),
    .AGE_W    (AGE_W),
    .NW_W     (NW_W)
  ) u_way (
    .tag_i         (rd_tag),
    .valid_i       (rd_valid),
    .dirty_i       (rd_dirty),
    .age_i         (rd_age),
    .req_tag_i     (req_tag),
    .nw_i          (nw),
    .store_i       (type_q == slc_pkg::REQ_STORE),
    .write_back_i  (write_back_q),
    .write_alloc_i (write_alloc_q),
    .words_i       (words),
    .tag_o         (wr_tag),
    .valid_o       (wr_valid),
    .dirty_o       (wr_dirty),
    .age_o         (wr_age),
    .res_o         (lk)
  );

  logic [CNT_W+WORDS_W-1:0] flush_prod;
  assign flush_prod = (CNT_W + WORDS_W)'(cnt_q) * (CNT_W + WORDS_W)'(words);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slc_pkg::ST_CLEAR;
      sweep_q     <= '0;
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      pend_q      <= pend_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q     <= type_d;
    addr_q     <= addr_d;
    cnt_q      <= cnt_d;
    res_q      <= res_d;
    rsp_q      <= rsp_d;
    rsp_data_q <= rsp_data_d;
  end

  always_comb begin
    state_d     = state_q;
    type_d      = type_q;
    addr_d      = addr_q;
    sweep_d     = sweep_q;
    pend_d      = pend_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    rsp_d       = rsp_q;
    rsp_data_d  = rsp_data_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    req_i.ready = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = row;
    mem_raddr   = row;
    mem_wdata   = upd_row;

    unique case (state_q)
      slc_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        mem_wdata = '0;
        sweep_d   = sweep_q + 1'b1;
        if (sweep_q == RW'(ROWS - 1)) begin
          sweep_d = '0;
          state_d = slc_pkg::ST_IDLE;
        end
      end
      slc_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          type_d = slc_pkg::req_type_e'(req_i.req_type);
          addr_d = req_i.address[AW-1:0];
          if (slc_pkg::req_type_e'(req_i.req_type) == slc_pkg::REQ_FLUSH) begin
            sweep_d = '0;
            pend_d  = 1'b0;
            cnt_d   = '0;
            state_d = slc_pkg::ST_FLUSH;
          end else begin
            state_d = slc_pkg::ST_READ;
          end
        end
      end
      slc_pkg::ST_READ: begin
        mem_re  = 1'b1;
        state_d = slc_pkg::ST_UPDATE;
      end
      slc_pkg::ST_UPDATE: begin
        mem_we  = lk.row_we;
        res_d   = lk;
        state_d = slc_pkg::ST_RESP;
      end
      slc_pkg::ST_FLUSH: begin
        mem_re    = 1'b1;
        mem_raddr = sweep_q;
        pend_d    = 1'b1;
        if (pend_q) begin
          cnt_d = cnt_q + row_pop;
        end
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == RW'(ROWS - 1)) begin
          sweep_d = '0;
          state_d = slc_pkg::ST_FLUSH_TAIL;
        end
      end
      slc_pkg::ST_FLUSH_TAIL: begin
        cnt_d   = cnt_q + row_pop;
        state_d = slc_pkg::ST_FLUSH_MUL;
      end
      slc_pkg::ST_FLUSH_MUL: begin
        res_d.hit            = 1'b0;
        res_d.row_we         = 1'b0;
        res_d.fetch_words    = '0;
        res_d.copyback_words = slc_pkg::CB_W'(flush_prod);
        state_d              = slc_pkg::ST_RESP;
      end
      slc_pkg::ST_RESP: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_d       = res_q;
          rsp_data_d  = data_req;
          rsp_valid_d = 1'b1;
          state_d     = slc_pkg::ST_IDLE;
        end
      end
      default: state_d = slc_pkg::ST_IDLE;
    endcase
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.hit            = rsp_q.hit;
  assign rsp_o.data_side      = rsp_data_q;
  assign rsp_o.fetch_words    = rsp_q.fetch_words;
  assign rsp_o.copyback_words = rsp_q.copyback_words;

  // a hit never fetches a block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.hit |-> rsp_o.fetch_words == '0)
    else $error("hit transaction reports fetched words");

  // no request is taken during the memory clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == slc_pkg::ST_CLEAR |-> !req_i.ready)
    else $error("request accepted while clearing");

  // the lookup always works on the row read in the cycle before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == slc_pkg::ST_UPDATE |-> $past(state_q) == slc_pkg::ST_READ)
    else $error("row update without a preceding read");

  // a flush never reports a hit or a fetch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == slc_pkg::ST_FLUSH_MUL |=> !res_q.hit && res_q.fetch_words == '0)
    else $error("flush transaction with hit or fetch");

endmodule

// ===== rtl/core/slc_row_mem.sv =====
// ----------------------------------------------------------------------------
// slc_row_mem: set row memory
// One row per set holding every way; one write port, one registered read port.
// ----------------------------------------------------------------------------
module slc_row_mem #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/core/slc_way_logic.sv =====
// ----------------------------------------------------------------------------
// slc_way_logic: lookup and replacement unit
// Tag match, victim choice, lru age update and word counts for one set row.
// ----------------------------------------------------------------------------
module slc_way_logic #(
  parameter int unsigned MAX_WAYS = slc_pkg::MAX_WAYS_DEF,
  parameter int unsigned TAG_W    = 30,
  parameter int unsigned AGE_W    = 3,
  parameter int unsigned NW_W     = 4
) (
  input  logic [TAG_W-1:0]            tag_i [MAX_WAYS],
  input  logic [MAX_WAYS-1:0]         valid_i,
  input  logic [MAX_WAYS-1:0]         dirty_i,
  input  logic [AGE_W-1:0]            age_i [MAX_WAYS],
  input  logic [TAG_W-1:0]            req_tag_i,
  input  logic [NW_W-1:0]             nw_i,
  input  logic                        store_i,
  input  logic                        write_back_i,
  input  logic                        write_alloc_i,
  input  logic [slc_pkg::WORDS_W-1:0] words_i,
  output logic [TAG_W-1:0]            tag_o [MAX_WAYS],
  output logic [MAX_WAYS-1:0]         valid_o,
  output logic [MAX_WAYS-1:0]         dirty_o,
  output logic [AGE_W-1:0]            age_o [MAX_WAYS],
  output slc_pkg::lk_res_t            res_o
);

  logic              hit, inv, fill;
  logic [AGE_W-1:0]  hw, iw, vw, w, best;
  logic [NW_W-1:0]   thr;
  logic [slc_pkg::CB_W-1:0] cb;

  always_comb begin
    hit  = 1'b0;
    inv  = 1'b0;
    hw   = '0;
    iw   = '0;
    vw   = '0;
    best = '0;
    for (int k = 0; k < MAX_WAYS; k++) begin
      if (!hit && NW_W'(k) < nw_i && valid_i[k] && tag_i[k] == req_tag_i) begin
        hit = 1'b1;
        hw  = AGE_W'(k);
      end
      if (!inv && NW_W'(k) < nw_i && !valid_i[k]) begin
        inv = 1'b1;
        iw  = AGE_W'(k);
      end
      // oldest line, lowest way on a tie
      if (NW_W'(k) < nw_i && age_i[k] > best) begin
        best = age_i[k];
        vw   = AGE_W'(k);
      end
    end

    fill = !hit && !(store_i && !write_alloc_i);
    w    = hit ? hw : (inv ? iw : vw);
    thr  = hit ? NW_W'(age_i[hw]) : nw_i;

    tag_o   = tag_i;
    valid_o = valid_i;
    dirty_o = dirty_i;
    age_o   = age_i;

    if (hit || fill) begin
      for (int k = 0; k < MAX_WAYS; k++) begin
        if (NW_W'(k) < nw_i && AGE_W'(k) != w && valid_i[k] && NW_W'(age_i[k]) < thr
            && (NW_W + 1)'(age_i[k]) + 1'b1 < (NW_W + 1)'(nw_i)) begin
          age_o[k] = age_i[k] + 1'b1;
        end
      end
      age_o[w] = '0;
    end

    cb = '0;
    if (hit) begin
      if (store_i && write_back_i) begin
        dirty_o[w] = 1'b1;
      end
    end else if (fill) begin
      tag_o[w]   = req_tag_i;
      valid_o[w] = 1'b1;
      dirty_o[w] = store_i && write_back_i;
      if (!inv && dirty_i[vw]) begin
        cb = slc_pkg::CB_W'(words_i);
      end
    end
    if (store_i && ((!hit && !fill) || !write_back_i)) begin
      cb = cb + 1'b1;
    end

    res_o.hit            = hit;
    res_o.row_we         = hit || fill;
    res_o.fetch_words    = fill ? words_i[slc_pkg::FETCH_W-1:0] : '0;
    res_o.copyback_words = cb;
  end

endmodule
